// File: hw/rtl/vfsd_pkg.sv
// ----------------------------------------------------------------------------
// vfsd_pkg: shared types and constants for the video frame stream deframer
// Header layout, field select codes, event codes and the result record.
// ----------------------------------------------------------------------------
package vfsd_pkg;

    // Header layout: five big-endian 32-bit words
    localparam logic [31:0] HDR_MAGIC = 32'h4d565046;
    localparam int          HDR_BYTES = 20;
    localparam int          IDX_W     = 5;

    // Width of offset and size on the result channel
    localparam int          OUT_W     = 21;

    // Header word selected by header_index[4:2]
    localparam logic [2:0]  FLD_MAGIC  = 3'd0;
    localparam logic [2:0]  FLD_WIDTH  = 3'd1;
    localparam logic [2:0]  FLD_HEIGHT = 3'd2;
    localparam logic [2:0]  FLD_FORMAT = 3'd3;

    // Result event kinds
    localparam logic        EVT_PAYLOAD = 1'b0;
    localparam logic        EVT_DROP    = 1'b1;

    typedef struct packed {
        logic              event_kind;
        logic [7:0]        payload_byte;
        logic [OUT_W-1:0]  payload_offset;
        logic              frame_done;
        logic [31:0]       pic_width;
        logic [31:0]       pic_height;
        logic [31:0]       pixel_format;
        logic [OUT_W-1:0]  payload_size;
    } vfsd_result_t;

endpackage

// File: hw/rtl/vfsd_parse.sv
// ----------------------------------------------------------------------------
// vfsd_parse: header collection, header check and payload counting
// Updates the framing state on every input transfer and forms the result.
// ----------------------------------------------------------------------------
module vfsd_parse
    import vfsd_pkg::*;
#(
    parameter int FRAME_STORE_BYTES = 2097152
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_fire,
    input  logic [7:0]   in_byte,
    output logic         res_valid,
    output vfsd_result_t res
);

    localparam int          CNT_W   = $clog2(FRAME_STORE_BYTES);
    localparam int          WIDE_W  = (CNT_W > OUT_W) ? CNT_W : OUT_W;
    localparam logic [31:0] MAX_LEN = 32'(FRAME_STORE_BYTES - HDR_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HDR_BYTES - 1);

    logic [IDX_W-1:0] header_index_reg, header_index_next;
    logic             in_payload_reg, in_payload_next;
    logic [CNT_W-1:0] payload_count_reg, payload_count_next;
    logic [31:0]      magic_word_reg, magic_word_next;
    logic [31:0]      width_word_reg, width_word_next;
    logic [31:0]      height_word_reg, height_word_next;
    logic [31:0]      format_word_reg, format_word_next;
    logic [31:0]      length_word_reg, length_word_next;

    logic [31:0]      count_inc;
    logic             last_byte;
    logic             hdr_bad;
    logic [WIDE_W-1:0] offset_wide;

    assign count_inc   = 32'(payload_count_reg) + 32'd1;
    assign last_byte   = (count_inc >= length_word_reg);
    assign offset_wide = WIDE_W'(payload_count_reg);
    assign hdr_bad     = (magic_word_next != HDR_MAGIC) || (length_word_next == 32'd0) ||
                         (length_word_next > MAX_LEN);

    // Advance header collection or payload count on each transfer
    always_comb begin
        header_index_next  = header_index_reg;
        in_payload_next    = in_payload_reg;
        payload_count_next = payload_count_reg;
        magic_word_next    = magic_word_reg;
        width_word_next    = width_word_reg;
        height_word_next   = height_word_reg;
        format_word_next   = format_word_reg;
        length_word_next   = length_word_reg;
        res_valid          = 1'b0;
        res.event_kind     = EVT_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.payload_offset = '0;
        res.frame_done     = 1'b0;

        if (in_fire && in_payload_reg) begin
            res_valid          = 1'b1;
            res.payload_byte   = in_byte;
            res.payload_offset = offset_wide[OUT_W-1:0];
            res.frame_done     = last_byte;
            if (last_byte) begin
                in_payload_next    = 1'b0;
                payload_count_next = '0;
            end else begin
                payload_count_next = count_inc[CNT_W-1:0];
            end
        end else if (in_fire) begin
            case (header_index_reg[4:2])
                FLD_MAGIC:  magic_word_next  = {magic_word_reg[23:0], in_byte};
                FLD_WIDTH:  width_word_next  = {width_word_reg[23:0], in_byte};
                FLD_HEIGHT: height_word_next = {height_word_reg[23:0], in_byte};
                FLD_FORMAT: format_word_next = {format_word_reg[23:0], in_byte};
                default:    length_word_next = {length_word_reg[23:0], in_byte};
            endcase
            if (header_index_reg == IDX_LAST) begin
                header_index_next = '0;
                if (hdr_bad) begin
                    res_valid      = 1'b1;
                    res.event_kind = EVT_DROP;
                end else begin
                    in_payload_next    = 1'b1;
                    payload_count_next = '0;
                end
            end else begin
                header_index_next = header_index_reg + IDX_W'(1);
            end
        end

        res.pic_width    = width_word_next;
        res.pic_height   = height_word_next;
        res.pixel_format = format_word_next;
        res.payload_size = length_word_next[OUT_W-1:0];
    end

    // Hold framing control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_index_reg  <= '0;
            in_payload_reg    <= 1'b0;
            payload_count_reg <= '0;
        end else begin
            header_index_reg  <= header_index_next;
            in_payload_reg    <= in_payload_next;
            payload_count_reg <= payload_count_next;
        end
    end

    // Hold header words
    always_ff @(posedge aclk) begin
        magic_word_reg  <= magic_word_next;
        width_word_reg  <= width_word_next;
        height_word_reg <= height_word_next;
        format_word_reg <= format_word_next;
        length_word_reg <= length_word_next;
    end

    ap_idx_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (header_index_reg == '0))
        else $error("header index not cleared while streaming payload");

    ap_count_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (32'(payload_count_reg) < length_word_reg))
        else $error("payload count reached frame length");

    ap_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        header_index_reg <= IDX_LAST)
        else $error("header index out of range");

endmodule

// File: hw/rtl/vfsd_out_buf.sv
// ----------------------------------------------------------------------------
// vfsd_out_buf: result register with skid stage
// Holds results toward the receiver and lets the input side run until the skid stage fills during stalls.
// ----------------------------------------------------------------------------
module vfsd_out_buf
    import vfsd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  vfsd_result_t push_data,
    output logic         in_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output vfsd_result_t m_data
);

    logic         main_valid_reg;
    logic         skid_valid_reg;
    vfsd_result_t main_data_reg;
    vfsd_result_t skid_data_reg;

    assign in_ready = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_data_reg;

    // Drain skid into main when the result register frees, else park stalled results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move result data
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_ready) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

    ap_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage full while result register empty");

    ap_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("result pushed into full buffer");

    ap_drain_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid stage not drained after transfer");

endmodule

// File: hw/rtl/video_frame_stream_deframer_unit.sv
// ----------------------------------------------------------------------------
// video_frame_stream_deframer_unit: framed video byte stream deframer
// Collects 20-byte frame headers, drops malformed ones, streams payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one stream byte per transfer (s_valid / s_ready).
//   Result channel m_*: one result per payload byte, plus one drop event for
//   each malformed header (bad magic, zero length or length above
//   FRAME_STORE_BYTES - 20). Header bytes of a good header give no result.
//   Each result carries the header words of the current frame.
// Output: each result is registered before it shows on m_*. Throughput: one
//   byte per cycle while s_ready is high, set by the single pass of header
//   shift and compare logic between the state and result registers.
// Stall: a result register and a one-entry skid stage hold results while
//   m_ready is low; s_ready drops only once the skid stage is full.
// Reset: aresetn (synchronous, active low) returns the block to header hunt
//   with an empty result buffer; no clearing pass is needed.
// ----------------------------------------------------------------------------
module video_frame_stream_deframer_unit
    import vfsd_pkg::*;
#(
    parameter int FRAME_STORE_BYTES = 2097152
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_stream_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_event_kind,
    output logic [7:0]        m_payload_byte,
    output logic [OUT_W-1:0]  m_payload_offset,
    output logic              m_frame_done,
    output logic [31:0]       m_pic_width,
    output logic [31:0]       m_pic_height,
    output logic [31:0]       m_pixel_format,
    output logic [OUT_W-1:0]  m_payload_size
);

    logic         in_fire;
    logic         res_valid;
    vfsd_result_t res;
    vfsd_result_t m_data;

    assign in_fire = s_valid && s_ready;

    vfsd_parse #(
        .FRAME_STORE_BYTES(FRAME_STORE_BYTES)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_stream_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    vfsd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Split result record onto ports
    assign m_event_kind     = m_data.event_kind;
    assign m_payload_byte   = m_data.payload_byte;
    assign m_payload_offset = m_data.payload_offset;
    assign m_frame_done     = m_data.frame_done;
    assign m_pic_width      = m_data.pic_width;
    assign m_pic_height     = m_data.pic_height;
    assign m_pixel_format   = m_data.pixel_format;
    assign m_payload_size   = m_data.payload_size;

endmodule

// File: tb/vfsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfsd_checker: result checker for the video frame stream deframer
// Watches both channels, tracks the header hunt and payload state for every
// accepted stream byte, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module vfsd_checker
    import vfsd_pkg::*;
#(
    parameter int FRAME_STORE_BYTES = 2097152
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_stream_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_event_kind,
    input  logic [7:0]        m_payload_byte,
    input  logic [OUT_W-1:0]  m_payload_offset,
    input  logic              m_frame_done,
    input  logic [31:0]       m_pic_width,
    input  logic [31:0]       m_pic_height,
    input  logic [31:0]       m_pixel_format,
    input  logic [OUT_W-1:0]  m_payload_size,
    output int                fail_count,
    output int                pending,
    output int                bytes_in,
    output int                payload_seen,
    output int                drops_seen,
    output int                frames_seen
);

    // Deframer state as the stream has driven it so far
    logic [IDX_W-1:0] hdr_pos;
    logic             streaming;
    logic [31:0]      magic_acc;
    logic [31:0]      width_acc;
    logic [31:0]      height_acc;
    logic [31:0]      format_acc;
    logic [31:0]      length_acc;
    logic [31:0]      bytes_sent;

    vfsd_result_t     awaited_outputs[$];

    assign pending = awaited_outputs.size();

    function automatic vfsd_result_t header_result(logic kind, logic [7:0] data,
                                                   logic [31:0] offset, logic done);
        vfsd_result_t r;
        r.event_kind     = kind;
        r.payload_byte   = data;
        r.payload_offset = offset[OUT_W-1:0];
        r.frame_done     = done;
        r.pic_width      = width_acc;
        r.pic_height     = height_acc;
        r.pixel_format   = format_acc;
        r.payload_size   = length_acc[OUT_W-1:0];
        return r;
    endfunction

    // Advance the state by one stream byte; return 1 when it yields a result
    function automatic bit deframe_byte(logic [7:0] b, output vfsd_result_t r);
        logic last;
        r = '0;
        if (streaming) begin
            last = (({1'b0, bytes_sent} + 33'd1) >= {1'b0, length_acc});
            r = header_result(EVT_PAYLOAD, b, bytes_sent, last);
            if (last) begin
                streaming  = 1'b0;
                hdr_pos    = '0;
                bytes_sent = '0;
            end else begin
                bytes_sent = bytes_sent + 32'd1;
            end
            return 1'b1;
        end

        case (hdr_pos[4:2])
            FLD_MAGIC:  magic_acc  = {magic_acc[23:0], b};
            FLD_WIDTH:  width_acc  = {width_acc[23:0], b};
            FLD_HEIGHT: height_acc = {height_acc[23:0], b};
            FLD_FORMAT: format_acc = {format_acc[23:0], b};
            default:    length_acc = {length_acc[23:0], b};
        endcase
        hdr_pos = hdr_pos + IDX_W'(1);
        if (hdr_pos < HDR_BYTES)
            return 1'b0;

        // Full header gathered: keep it or drop it
        hdr_pos = '0;
        if (magic_acc != HDR_MAGIC || length_acc == 32'd0 ||
            length_acc > 32'(FRAME_STORE_BYTES - HDR_BYTES)) begin
            r = header_result(EVT_DROP, 8'd0, 32'd0, 1'b0);
            return 1'b1;
        end
        streaming  = 1'b1;
        bytes_sent = '0;
        return 1'b0;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
            fail_count++;
        end
    endfunction

    initial begin
        fail_count   = 0;
        bytes_in     = 0;
        payload_seen = 0;
        drops_seen   = 0;
        frames_seen  = 0;
    end

    always @(posedge aclk) begin
        vfsd_result_t nxt;
        vfsd_result_t exp;
        if (!aresetn) begin
            hdr_pos    = '0;
            streaming  = 1'b0;
            magic_acc  = '0;
            width_acc  = '0;
            height_acc = '0;
            format_acc = '0;
            length_acc = '0;
            bytes_sent = '0;
            awaited_outputs.delete();
        end else begin
            // Predict from each accepted stream byte
            if (s_valid && s_ready) begin
                bytes_in++;
                if (deframe_byte(s_stream_byte, nxt))
                    awaited_outputs.push_back(nxt);
            end

            // Compare each accepted result with the oldest prediction
            if (m_valid && m_ready) begin
                if (awaited_outputs.size() == 0) begin
                    $error("unexpected result transfer: kind %0b byte 0x%0h",
                           m_event_kind, m_payload_byte);
                    fail_count++;
                end else begin
                    exp = awaited_outputs.pop_front();
                    check_field("event_kind", 32'(exp.event_kind), 32'(m_event_kind));
                    check_field("payload_byte", 32'(exp.payload_byte), 32'(m_payload_byte));
                    check_field("payload_offset", 32'(exp.payload_offset),
                                32'(m_payload_offset));
                    check_field("frame_done", 32'(exp.frame_done), 32'(m_frame_done));
                    check_field("pic_width", exp.pic_width, m_pic_width);
                    check_field("pic_height", exp.pic_height, m_pic_height);
                    check_field("pixel_format", exp.pixel_format, m_pixel_format);
                    check_field("payload_size", 32'(exp.payload_size),
                                32'(m_payload_size));
                    if (exp.event_kind == EVT_DROP)
                        drops_seen++;
                    else
                        payload_seen++;
                    if (exp.event_kind == EVT_PAYLOAD && exp.frame_done)
                        frames_seen++;
                end
            end
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the video frame stream deframer
// Builds a framed byte stream (directed corner frames, then mostly good frames
// with random content mixed with bad, truncated and noise headers), sends it
// in random bursts against a stalling receiver, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import vfsd_pkg::*;

    localparam int FRAME_STORE  = 2097152;
    localparam int RANDOM_BYTES = 1500;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_stream_byte = 8'd0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_event_kind;
    logic [7:0]        m_payload_byte;
    logic [OUT_W-1:0]  m_payload_offset;
    logic              m_frame_done;
    logic [31:0]       m_pic_width;
    logic [31:0]       m_pic_height;
    logic [31:0]       m_pixel_format;
    logic [OUT_W-1:0]  m_payload_size;

    int                fail_count;
    int                pending;
    int                bytes_in;
    int                payload_seen;
    int                drops_seen;
    int                frames_seen;
    int                cycle_count = 0;

    rx_mode_t          rx_mode = RX_OPEN;
    int                rx_left = 0;

    logic [7:0]        stream_bytes[$];

    video_frame_stream_deframer_unit #(
        .FRAME_STORE_BYTES (FRAME_STORE)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stream_byte    (s_stream_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_payload_byte   (m_payload_byte),
        .m_payload_offset (m_payload_offset),
        .m_frame_done     (m_frame_done),
        .m_pic_width      (m_pic_width),
        .m_pic_height     (m_pic_height),
        .m_pixel_format   (m_pixel_format),
        .m_payload_size   (m_payload_size)
    );

    vfsd_checker #(
        .FRAME_STORE_BYTES (FRAME_STORE)
    ) checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stream_byte    (s_stream_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_payload_byte   (m_payload_byte),
        .m_payload_offset (m_payload_offset),
        .m_frame_done     (m_frame_done),
        .m_pic_width      (m_pic_width),
        .m_pic_height     (m_pic_height),
        .m_pixel_format   (m_pixel_format),
        .m_payload_size   (m_payload_size),
        .fail_count       (fail_count),
        .pending          (pending),
        .bytes_in         (bytes_in),
        .payload_seen     (payload_seen),
        .drops_seen       (drops_seen),
        .frames_seen      (frames_seen)
    );

    // Clock: 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: hold each stall mode for a random stretch of cycles
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(4, 64);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= 1'b0;
        endcase
    end

    task automatic push_word(logic [31:0] w);
        stream_bytes.push_back(w[31:24]);
        stream_bytes.push_back(w[23:16]);
        stream_bytes.push_back(w[15:8]);
        stream_bytes.push_back(w[7:0]);
    endtask

    task automatic push_header(logic [31:0] magic, logic [31:0] w, logic [31:0] h,
                               logic [31:0] fmt, logic [31:0] len);
        push_word(magic);
        push_word(w);
        push_word(h);
        push_word(fmt);
        push_word(len);
    endtask

    task automatic push_noise(int n);
        repeat (n) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_directed();
        // Smallest frames with payload byte extremes and header word extremes
        push_header(HDR_MAGIC, 32'd0, 32'd0, 32'd0, 32'd2);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        push_header(HDR_MAGIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        stream_bytes.push_back(8'hA5);
        // Magic off by one bit: dropped, no resync inside it
        push_header(HDR_MAGIC ^ 32'h1, 32'd640, 32'd480, 32'h5955_5956, 32'd16);
        push_header(HDR_MAGIC ^ 32'h8000_0000, 32'd1, 32'd1, 32'd1, 32'd1);
        // Zero length
        push_header(HDR_MAGIC, 32'd320, 32'd240, 32'h3231_5659, 32'd0);
        // Length one past the frame store limit, and all ones
        push_header(HDR_MAGIC, 32'd720, 32'd576, 32'h4745_5259,
                    32'(FRAME_STORE - HDR_BYTES + 1));
        push_header(HDR_MAGIC, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF);
        // Good frame straight after drops
        push_header(HDR_MAGIC, 32'd64, 32'd48, 32'h3231_5659, 32'd3);
        push_noise(3);
        // Truncated header padded to a full header slot
        push_word(HDR_MAGIC);
        push_noise(16);
    endtask

    task automatic build_random();
        int stop_at;
        int pick;
        int len;
        int cut;
        stop_at = stream_bytes.size() + RANDOM_BYTES;
        while (stream_bytes.size() < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // Well-formed frame with random content
                if ($urandom_range(0, 99) == 0)
                    len = $urandom_range(500, 2500);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(25, 200);
                else
                    len = $urandom_range(1, 24);
                push_header(HDR_MAGIC, $urandom(), $urandom(), $urandom(), 32'(len));
                push_noise(len);
            end else if (pick < 78) begin
                push_header(HDR_MAGIC ^ (32'h1 << $urandom_range(0, 31)),
                            $urandom(), $urandom(), $urandom(),
                            32'($urandom_range(1, 64)));
            end else if (pick < 82) begin
                push_header(HDR_MAGIC, $urandom(), $urandom(), $urandom(), 32'd0);
            end else if (pick < 86) begin
                if ($urandom_range(0, 1) == 0)
                    len = FRAME_STORE - HDR_BYTES + 1 + $urandom_range(0, 1000);
                else
                    len = $urandom() | 32'h0020_0000;
                push_header(HDR_MAGIC, $urandom(), $urandom(), $urandom(), 32'(len));
            end else if (pick < 93) begin
                // Header cut short, then filler up to the next header slot
                cut = $urandom_range(1, 4);
                push_word(HDR_MAGIC);
                repeat (4 - cut) stream_bytes.pop_back();
                push_noise(HDR_BYTES - cut);
            end else begin
                push_noise(20 * $urandom_range(1, 2));
            end
        end
    endtask

    initial begin
        int idx;
        int burst;
        int gap;
        build_directed();
        build_random();

        // Hold reset, then release
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Send the stream in bursts separated by random gaps
        idx = 0;
        while (idx < stream_bytes.size()) begin
            burst = $urandom_range(1, 48);
            while (burst > 0 && idx < stream_bytes.size()) begin
                s_valid       <= 1'b1;
                s_stream_byte <= stream_bytes[idx];
                do @(posedge aclk); while (!s_ready);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        // Drain remaining results, then give stray results time to show
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d stream bytes: %0d payload bytes in %0d complete frames,",
                 bytes_in, payload_seen, frames_seen);
        $display("and %0d dropped headers, with bursty input and a stalling receiver.",
                 drops_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/vfsd_pkg.sv
hw/rtl/vfsd_parse.sv
hw/rtl/vfsd_out_buf.sv
hw/rtl/video_frame_stream_deframer_unit.sv
tb/vfsd_checker.sv
tb/tb_top.sv
